// ===== rtl/lfbd_pkg.sv =====
package lfbd_pkg;

   // parser phase: flag byte, code byte, second byte of a pointer
   typedef enum logic [1:0] {
      PH_FLAG = 2'd0,
      PH_CODE = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   // work handed from the parser to the executor
   typedef enum logic [1:0] {
      CMD_LIT  = 2'd0,
      CMD_COPY = 2'd1,
      CMD_END  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   lit;
      logic [11:0]  offset;
      logic [3:0]   cnt;
   } cmd_type;

   // executor sequence
   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_FETCH = 2'd1,
      BK_COPY  = 2'd2
   } back_state_type;

   // a pointer count of zero closes the stream
   localparam logic [3:0] CNT_END = 4'h0;
   // index of the last code in a flag group
   localparam logic [2:0] GROUP_LAST = 3'd7;

endpackage

// ===== rtl/lzss_flag_byte_decompressor_core.sv =====
// LZSS decompressor, 12-bit distance and 4-bit count, flag byte per eight codes.
// One compressed byte is taken per request; a parser classifies it and queues a
// command (literal, copy or end of stream) in a two-entry queue, and an
// executor drives the results. Flag bytes and first pointer bytes give no
// result. A literal goes from the idle executor straight into the output
// register. A pointer with count n gives n+1 bytes: the source address is
// formed and registered, the history is read, then one byte per cycle while
// the output is not stalled, set by the single read port of the history ring.
// The history needs no clearing pass after reset: positions not yet written
// since reset read as zero. Results leave through an output register, so
// rsp_stall holds the executor and, once the queue fills, the request side.
module lzss_flag_byte_decompressor_core
   import lfbd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 4096
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);

   logic    push, q_full, q_valid, q_pop;
   cmd_type push_cmd, q_cmd;

   assign req_stall = q_full;

   // parser
   lfbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // command queue
   lfbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   // executor with history ring
   lfbd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_valid),
      .cmd            (q_cmd),
      .cmd_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

// ===== rtl/lfbd_front.sv =====
module lfbd_front
   import lfbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       push,
   output cmd_type    push_cmd
);

   phase_type  phase_ff, phase_in;
   logic [7:0] flag_ff, flag_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] high_ff, high_in;
   logic       accept;

   assign accept = req_valid && !req_stall;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAG;
         flag_ff  <= '0;
         count_ff <= '0;
         high_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         count_ff <= count_in;
         high_ff  <= high_in;
      end
   end

   // classify each request and issue a command where it leads to output
   always_comb begin
      phase_in        = phase_ff;
      flag_in         = flag_ff;
      count_in        = count_ff;
      high_in         = high_ff;
      push            = 1'b0;
      push_cmd.kind   = CMD_LIT;
      push_cmd.lit    = req_in_byte;
      push_cmd.offset = {high_ff, req_in_byte[7:4]};
      push_cmd.cnt    = req_in_byte[3:0];
      case (phase_ff)
         PH_CODE: begin
            if (accept) begin
               if (flag_ff[0]) begin
                  high_in  = req_in_byte;
                  phase_in = PH_LOW;
               end else begin
                  push          = 1'b1;
                  push_cmd.kind = CMD_LIT;
                  flag_in       = flag_ff >> 1;
                  count_in      = count_ff + 3'd1;
                  phase_in      = (count_ff == GROUP_LAST) ? PH_FLAG : PH_CODE;
               end
            end
         end
         PH_LOW: begin
            if (accept) begin
               push = 1'b1;
               if (req_in_byte[3:0] == CNT_END) begin
                  push_cmd.kind = CMD_END;
                  flag_in       = '0;
                  count_in      = '0;
                  phase_in      = PH_FLAG;
               end else begin
                  push_cmd.kind = CMD_COPY;
                  flag_in       = flag_ff >> 1;
                  count_in      = count_ff + 3'd1;
                  phase_in      = (count_ff == GROUP_LAST) ? PH_FLAG : PH_CODE;
               end
            end
         end
         default: begin
            // flag byte, also the unused phase code
            if (accept) begin
               flag_in  = req_in_byte;
               count_in = '0;
               phase_in = PH_CODE;
            end
         end
      endcase
   end

endmodule

// ===== rtl/lfbd_queue.sv =====
module lfbd_queue
   import lfbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/lfbd_back.sv =====
module lfbd_back
   import lfbd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 4096
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);

   localparam int          AW      = $clog2(HISTORY_DEPTH);
   localparam logic [AW:0] DEPTH_X = (AW + 1)'(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST  = AW'(HISTORY_DEPTH - 1);

   logic [7:0] hist_mem [HISTORY_DEPTH];

   back_state_type state_ff, state_in;
   logic [AW-1:0]  wp_ff, wp_in;
   logic           wrapped_ff, wrapped_in;
   logic [AW-1:0]  src_ff, src_in;
   logic [3:0]     cnt_ff, cnt_in;

   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;
   logic           out_end_ff, out_end_in;

   logic           we, re;
   logic [AW-1:0]  wa, ra;
   logic [7:0]     wd;
   logic [7:0]     rd_ff, byp_data_ff;
   logic           byp_ff, ok_ff;
   logic [7:0]     hist_byte;
   logic           out_free;
   logic [AW:0]    src_diff;
   logic [AW-1:0]  src_start;
   logic [AW-1:0]  src_next;

   assign out_free       = !out_valid_ff || !rsp_stall;
   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_last   = out_last_ff;
   assign rsp_stream_end = out_end_ff;

   // copy source: write position less distance, wrapped round the ring
   assign src_diff  = {1'b0, wp_ff} - (AW + 1)'(cmd.offset) - (AW + 1)'(1);
   assign src_start = src_diff[AW] ? AW'(src_diff + DEPTH_X) : src_diff[AW-1:0];
   assign src_next  = (src_ff == LAST) ? '0 : src_ff + 1'b1;

   // entries never written since reset read as zero
   assign hist_byte = !ok_ff ? 8'h00 : (byp_ff ? byp_data_ff : rd_ff);

   // history ring, write-first forwarding for overlapping copies
   always_ff @(posedge clock) begin
      if (we) begin
         hist_mem[wa] <= wd;
      end
      if (re) begin
         rd_ff       <= hist_mem[ra];
         byp_ff      <= we && (wa == ra);
         byp_data_ff <= wd;
         ok_ff       <= wrapped_ff || (ra < wp_ff) || (we && (wa == ra));
      end
   end

   // control and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      cnt_ff      <= cnt_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      src_in       = src_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      cmd_pop      = 1'b0;
      we           = 1'b0;
      wa           = wp_ff;
      wd           = cmd.lit;
      re           = 1'b0;
      ra           = src_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_LIT: begin
                     if (out_free) begin
                        we           = 1'b1;
                        wd           = cmd.lit;
                        out_valid_in = 1'b1;
                        out_byte_in  = cmd.lit;
                        out_last_in  = 1'b1;
                        out_end_in   = 1'b0;
                        cmd_pop      = 1'b1;
                     end
                  end
                  CMD_COPY: begin
                     src_in   = src_start;
                     cnt_in   = cmd.cnt;
                     state_in = BK_FETCH;
                  end
                  default: begin
                     // end of stream marker
                     if (out_free) begin
                        out_valid_in = 1'b1;
                        out_byte_in  = 8'h00;
                        out_last_in  = 1'b1;
                        out_end_in   = 1'b1;
                        cmd_pop      = 1'b1;
                     end
                  end
               endcase
            end
         end
         BK_FETCH: begin
            re       = 1'b1;
            ra       = src_ff;
            state_in = BK_COPY;
         end
         BK_COPY: begin
            if (out_free) begin
               we           = 1'b1;
               wd           = hist_byte;
               out_valid_in = 1'b1;
               out_byte_in  = hist_byte;
               out_last_in  = (cnt_ff == 4'd0);
               out_end_in   = 1'b0;
               src_in       = src_next;
               cnt_in       = cnt_ff - 4'd1;
               if (cnt_ff == 4'd0) begin
                  cmd_pop  = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  re = 1'b1;
                  ra = src_next;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      // write position advances with every stored byte
      if (we) begin
         wp_in = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
         if (wp_ff == LAST) begin
            wrapped_in = 1'b1;
         end
      end
   end

   // checks
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_end_ff |-> out_last_ff && (out_byte_ff == 8'h00))
      else $error("end of stream result without last flag or with data");

   a_fetch_then_copy: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_FETCH |=> state_ff == BK_COPY)
      else $error("history fetch not followed by copy");

   a_no_pop_in_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff != BK_FETCH && cmd_valid)
      else $error("command released at the wrong time");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      we |-> out_free)
      else $error("history written while output register blocked");

endmodule

// ===== verif/lzss_flag_byte_decompressor_core_test.sv =====
`timescale 1ns / 100ps

module lzss_flag_byte_decompressor_core_test;
   import lfbd_pkg::*;

   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int RING_SIZE      = 4096;
   localparam int TOTAL_REQUESTS = 420;
   localparam int DRAIN_CYCLES   = 40;

   // one decompressed result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } out_rec_type;

   typedef enum logic {
      ROW_PRED  = 1'b0,
      ROW_TYPED = 1'b1
   } row_kind_type;

   // one directed request, with up to two results written out by hand
   typedef struct packed {
      logic [7:0]   code;
      row_kind_type kind;
      logic [1:0]   n_res;
      out_rec_type  r0;
      out_rec_type  r1;
   } plan_row_type;

   localparam out_rec_type NO_REC = '0;

   // directed stream: zero reads, extremes of distance and count, overlap, end of stream
   localparam plan_row_type PLAN [22] = '{
      '{8'h02, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'hFF, ROW_TYPED, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_REC},
      '{8'hFF, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'hF1, ROW_TYPED, 2'd2, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0}},
      '{8'h00, ROW_TYPED, 2'd1, '{8'h00, 1'b1, 1'b0}, NO_REC},
      '{8'h55, ROW_TYPED, 2'd1, '{8'h55, 1'b1, 1'b0}, NO_REC},
      '{8'hAA, ROW_TYPED, 2'd1, '{8'hAA, 1'b1, 1'b0}, NO_REC},
      '{8'h80, ROW_TYPED, 2'd1, '{8'h80, 1'b1, 1'b0}, NO_REC},
      '{8'h01, ROW_TYPED, 2'd1, '{8'h01, 1'b1, 1'b0}, NO_REC},
      '{8'h7F, ROW_TYPED, 2'd1, '{8'h7F, 1'b1, 1'b0}, NO_REC},
      '{8'hFF, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'h00, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'h0F, ROW_PRED,  2'd0, NO_REC, NO_REC},
      '{8'h00, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'h12, ROW_PRED,  2'd0, NO_REC, NO_REC},
      '{8'h00, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'h00, ROW_TYPED, 2'd1, '{8'h00, 1'b1, 1'b1}, NO_REC},
      '{8'h81, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'h00, ROW_TYPED, 2'd0, NO_REC, NO_REC},
      '{8'h21, ROW_PRED,  2'd0, NO_REC, NO_REC},
      '{8'hC3, ROW_TYPED, 2'd1, '{8'hC3, 1'b1, 1'b0}, NO_REC},
      '{8'h3C, ROW_TYPED, 2'd1, '{8'h3C, 1'b1, 1'b0}, NO_REC}
   };

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_stream_end;

   // decoder mirror
   logic [7:0]  ring_copy [RING_SIZE];
   logic [11:0] ring_wpos;
   logic [7:0]  group_flags;
   logic [2:0]  group_pos;
   phase_type   parse_phase;
   logic [7:0]  ptr_high;
   out_rec_type step_bytes [$];

   // results still owed by the block
   out_rec_type owed_bytes [$];
   out_rec_type due_rec;

   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned sent_count    = 0;
   int unsigned results_seen  = 0;
   int unsigned ends_seen     = 0;
   int unsigned bytes_kept    = 0;
   int          stall_hold    = 0;

   lzss_flag_byte_decompressor_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gap length: mostly none or short, now and then long, none at all in calm windows
   function automatic int idle_len();
      int pick;
      if ((cycle_count % 1024) < 160) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic note_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("mismatch at result %0d (cycle %0d): %s got %02h want %02h",
                  results_seen, cycle_count, what, got, want);
      end
   endtask

   // append to the results of the current byte
   task automatic add_step(input out_rec_type r);
      step_bytes = {step_bytes, r};
   endtask

   // append to the results owed by the block
   task automatic add_owed(input out_rec_type r);
      owed_bytes = {owed_bytes, r};
   endtask

   // byte into the ring copy
   task automatic keep_byte(input logic [7:0] b);
      ring_copy[ring_wpos] = b;
      ring_wpos = ring_wpos + 12'd1;
      bytes_kept++;
   endtask

   // move on to the next code of the flag group
   task automatic next_group_code();
      group_flags = group_flags >> 1;
      group_pos   = group_pos + 3'd1;
      parse_phase = (group_pos == 3'd0) ? PH_FLAG : PH_CODE;
   endtask

   // decode one compressed byte into step_bytes
   task automatic decode_byte(input logic [7:0] b);
      logic [11:0] offset;
      logic [11:0] src;
      logic [3:0]  cnt;
      logic [7:0]  v;
      step_bytes.delete();
      case (parse_phase)
         PH_CODE: begin
            if (group_flags[0]) begin
               ptr_high    = b;
               parse_phase = PH_LOW;
            end else begin
               keep_byte(b);
               add_step('{b, 1'b1, 1'b0});
               next_group_code();
            end
         end
         PH_LOW: begin
            offset = {ptr_high, b[7:4]};
            cnt    = b[3:0];
            if (cnt == CNT_END) begin
               add_step('{8'h00, 1'b1, 1'b1});
               group_flags = 8'h00;
               group_pos   = 3'd0;
               parse_phase = PH_FLAG;
            end else begin
               // ring index wraps at 12 bits, so overlapping copies fall out naturally
               src = ring_wpos - offset - 12'd1;
               for (int i = 0; i <= cnt; i++) begin
                  v = ring_copy[src];
                  keep_byte(v);
                  add_step('{v, (i == cnt), 1'b0});
                  src = src + 12'd1;
               end
               next_group_code();
            end
         end
         default: begin
            group_flags = b;
            group_pos   = 3'd0;
            parse_phase = PH_CODE;
         end
      endcase
   endtask

   // one request through the handshake
   task automatic send_request(input logic [7:0] code);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= code;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, owed_bytes.size());
         $display("status: fail");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 6);
      end else begin
         stall_hold <= idle_len();
         if (idle_len() > 0) rsp_stall <= 1'b1;
      end
   end

   // result checking against the oldest owed byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (owed_bytes.size() == 0) begin
            note_mismatch("unexpected result, out_byte", rsp_out_byte, 8'h00);
         end else begin
            due_rec = owed_bytes.pop_front();
            if (due_rec.stream_end) ends_seen++;
            if (rsp_out_byte !== due_rec.out_byte)
               note_mismatch("out_byte", rsp_out_byte, due_rec.out_byte);
            if (rsp_run_last !== due_rec.run_last)
               note_mismatch("run_last", {7'd0, rsp_run_last}, {7'd0, due_rec.run_last});
            if (rsp_stream_end !== due_rec.stream_end)
               note_mismatch("stream_end", {7'd0, rsp_stream_end},
                             {7'd0, due_rec.stream_end});
         end
      end
   end

   // stimulus
   initial begin
      logic [7:0] code;
      int         noise_left;
      int         pick;

      noise_left  = 0;
      ring_wpos   = 12'd0;
      group_flags = 8'h00;
      group_pos   = 3'd0;
      parse_phase = PH_FLAG;
      ptr_high    = 8'h00;
      foreach (ring_copy[i]) ring_copy[i] = 8'h00;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (PLAN[i]) begin
         send_request(PLAN[i].code);
         decode_byte(PLAN[i].code);
         if (PLAN[i].kind == ROW_TYPED) begin
            if (PLAN[i].n_res > 2'd0) add_owed(PLAN[i].r0);
            if (PLAN[i].n_res > 2'd1) add_owed(PLAN[i].r1);
         end else begin
            foreach (step_bytes[j]) add_owed(step_bytes[j]);
         end
      end

      // random: mostly well-formed groups, long copies, bursts of noise
      while (sent_count < TOTAL_REQUESTS) begin
         if (noise_left == 0 && $urandom_range(0, 99) < 2)
            noise_left = $urandom_range(1, 12);
         if (noise_left > 0) begin
            code = 8'($urandom);
            noise_left--;
         end else begin
            case (parse_phase)
               PH_FLAG: begin
                  pick = $urandom_range(0, 9);
                  if (pick < 5)      code = 8'hFF;
                  else if (pick < 8) code = 8'($urandom);
                  else               code = 8'($urandom | $urandom);
               end
               PH_LOW: begin
                  code[7:4] = 4'($urandom);
                  pick = $urandom_range(0, 99);
                  if (pick < 4)       code[3:0] = CNT_END;
                  else if (pick < 74) code[3:0] = 4'($urandom_range(12, 15));
                  else                code[3:0] = 4'($urandom_range(1, 15));
               end
               default: code = 8'($urandom);
            endcase
         end
         send_request(code);
         decode_byte(code);
         foreach (step_bytes[j]) add_owed(step_bytes[j]);
      end
      req_valid <= 1'b0;

      // drain, then a short tail for stray results
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d compressed bytes, checked %0d results, %0d of them stream ends",
               sent_count, results_seen, ends_seen);
      $display("%0d bytes passed through the history ring, %0d mismatches",
               bytes_kept, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
